// File: design/gdd_pkg.sv
// shared types, constants and calendar tables for the date difference pipeline
package gdd_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int DIST_W  = 22;
  localparam int DNUM_W  = 23;
  localparam int QUOT_W  = 8;
  localparam int PROD_W  = 26;
  localparam int RECIP_SHIFT = 17;

  // ceil(2^17 / 25): exact quotient for dividends below 43690
  localparam logic [PROD_W-1:0] RECIP_25 = PROD_W'(5243);
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

  typedef struct packed {
    logic s1;
    logic s2;
  } gdd_adv_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] r;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = DAY_W'(31);
      4'd4, 4'd6, 4'd9, 4'd11:                   r = DAY_W'(30);
      4'd2:                                      r = DAY_W'(28);
      default:                                   r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    logic [8:0] r;
    unique case (m)
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// File: design/gdd_date_unit.sv
// two-stage date check and day number from year 0 for one date
module gdd_date_unit #(
  parameter int YEAR_MAX = 9999
) (
  input  logic                        clk,
  input  gdd_pkg::gdd_adv_t           adv,
  input  logic [gdd_pkg::YEAR_W-1:0]  year,
  input  logic [gdd_pkg::MONTH_W-1:0] month,
  input  logic [gdd_pkg::DAY_W-1:0]   day,
  output logic                        date_ok,
  output logic [gdd_pkg::DNUM_W-1:0]  day_num
);
  import gdd_pkg::*;

  // stage 1: constant-reciprocal quotients and 365 * year
  logic [YEAR_W:0]        sum_c;
  logic [YEAR_W:0]        sum_q;
  logic [PROD_W-1:0]      prod_y;
  logic [PROD_W-1:0]      prod_c;
  logic [PROD_W-1:0]      prod_q;
  logic [DNUM_W-1:0]      y365_next;

  logic [YEAR_W-1:0]      year_r;
  logic [MONTH_W-1:0]     month_r;
  logic [DAY_W-1:0]       day_r;
  logic                   year_ok;
  logic [QUOT_W-1:0]      q_y;
  logic [QUOT_W-1:0]      q_c;
  logic [QUOT_W-1:0]      q_q;
  logic [DNUM_W-1:0]      y365;

  always_comb begin
    sum_c     = {1'b0, year} + (YEAR_W+1)'(99);
    sum_q     = {1'b0, year} + (YEAR_W+1)'(399);
    // x / 100 = (x >> 2) / 25, x / 400 = (x >> 4) / 25
    prod_y    = PROD_W'(year[YEAR_W-1:2]) * RECIP_25;
    prod_c    = PROD_W'(sum_c[YEAR_W:2]) * RECIP_25;
    prod_q    = PROD_W'(sum_q[YEAR_W:4]) * RECIP_25;
    y365_next = DNUM_W'(year) * DNUM_W'(365);
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      year_r  <= year;
      month_r <= month;
      day_r   <= day;
      year_ok <= ({1'b0, 16'(year)} <= 17'(YEAR_MAX));
      q_y     <= prod_y[RECIP_SHIFT +: QUOT_W];
      q_c     <= prod_c[RECIP_SHIFT +: QUOT_W];
      q_q     <= prod_q[RECIP_SHIFT +: QUOT_W];
      y365    <= y365_next;
    end
  end

  // stage 2: leap rule, validity and day number
  logic [YEAR_W:0]    y4_sum;
  logic               cent_year;
  logic               leap;
  logic [DAY_W-1:0]   lim;
  logic               ok_next;
  logic [DNUM_W-1:0]  dn_next;

  always_comb begin
    y4_sum    = {1'b0, year_r} + (YEAR_W+1)'(3);
    cent_year = ((YEAR_W+1)'(q_y) * (YEAR_W+1)'(100)) == {1'b0, year_r};
    leap      = (year_r[1:0] == 2'b00) && (!cent_year || (q_y[1:0] == 2'b00));
    lim       = month_len(month_r);
    if (month_r == MONTH_FEB && leap) begin
      lim = DAY_W'(29);
    end
    ok_next   = year_ok && (month_r >= MONTH_JAN) && (month_r <= MONTH_DEC)
                && (day_r != '0) && (day_r <= lim);
    dn_next   = y365 + DNUM_W'(y4_sum[YEAR_W:2]) - DNUM_W'(q_c) + DNUM_W'(q_q)
                + DNUM_W'(days_before(month_r))
                + DNUM_W'(leap && (month_r > MONTH_FEB))
                + DNUM_W'(day_r) - DNUM_W'(1);
  end

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      date_ok <= ok_next;
      day_num <= dn_next;
    end
  end

endmodule

// File: design/gregorian_date_difference.sv
// Gregorian date difference: takes two dates per transaction and returns a
// validity flag for each and the absolute number of days between them (0 when
// either date is invalid, saturated to 22 bits). Fully pipelined: one
// transaction per clock while the output is not stalled; two date units each
// spend one stage on constant-reciprocal divisions and one on the leap rule
// and day number, and a third stage takes the absolute difference into the
// output register. A stall on the output holds the pipeline without loss.
// YEAR_MAX sets the highest valid year.
module gregorian_date_difference #(
  parameter int YEAR_MAX = 9999
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // year_a[13:0], month_a[17:14], day_a[22:18], year_b[36:23],
  // month_b[40:37], day_b[45:41], zero fill
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // first_valid[0], second_valid[1], day_distance[23:2]
  output logic [23:0] m_tdata
);
  import gdd_pkg::*;

  logic              v1;
  logic              v2;
  logic              adv_out;
  gdd_adv_t          adv;
  logic              ok_a;
  logic              ok_b;
  logic [DNUM_W-1:0] dn_a;
  logic [DNUM_W-1:0] dn_b;
  logic [DNUM_W-1:0] diff;
  logic [DIST_W-1:0] dist_next;

  assign adv_out  = !m_tvalid || m_tready;
  assign adv.s2   = !v2 || adv_out;
  assign adv.s1   = !v1 || adv.s2;
  assign s_tready = adv.s1;

  gdd_date_unit #(.YEAR_MAX(YEAR_MAX)) u_date_a (
    .clk     (clk),
    .adv     (adv),
    .year    (s_tdata[13:0]),
    .month   (s_tdata[17:14]),
    .day     (s_tdata[22:18]),
    .date_ok (ok_a),
    .day_num (dn_a)
  );

  gdd_date_unit #(.YEAR_MAX(YEAR_MAX)) u_date_b (
    .clk     (clk),
    .adv     (adv),
    .year    (s_tdata[36:23]),
    .month   (s_tdata[40:37]),
    .day     (s_tdata[45:41]),
    .date_ok (ok_b),
    .day_num (dn_b)
  );

  always_comb begin
    diff = (dn_a >= dn_b) ? (dn_a - dn_b) : (dn_b - dn_a);
    if (!(ok_a && ok_b)) begin
      dist_next = '0;
    end else if (diff > DNUM_W'(DIST_MAX)) begin
      dist_next = DIST_MAX;
    end else begin
      dist_next = diff[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (adv.s1) begin
        v1 <= s_tvalid;
      end
      if (adv.s2) begin
        v2 <= v1;
      end
      if (adv_out) begin
        m_tvalid <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      m_tdata <= {dist_next, ok_b, ok_a};
    end
  end

endmodule

// File: bench/tb_gregorian_date_difference.sv
// testbench for the gregorian date difference pipeline with a day count predictor
module tb_gregorian_date_difference;
  import gdd_pkg::*;

  localparam int YEAR_LIMIT   = 9999;
  localparam int DISTANCE_CAP = 4194303;
  localparam int RANDOM_ITEMS = 2000;
  localparam int DRAIN_CYCLES = 12;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } cal_date_t;

  typedef struct {
    logic              first_ok;
    logic              second_ok;
    logic [DIST_W-1:0] distance;
  } date_verdict_t;

  class date_scoreboard;
    date_verdict_t awaited[$];
    int            errors;

    function new();
      errors = 0;
    endfunction

    function automatic bit is_leap(int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned month_days(int unsigned y, int unsigned m);
      int unsigned r;
      case (m)
        2:            r = is_leap(y) ? 29 : 28;
        4, 6, 9, 11:  r = 30;
        default:      r = 31;
      endcase
      return r;
    endfunction

    function automatic bit date_ok(cal_date_t dt);
      if (dt.year > YEAR_LIMIT || dt.month < 1 || dt.month > 12 || dt.day < 1) begin
        return 1'b0;
      end
      return dt.day <= month_days(dt.year, dt.month);
    endfunction

    // days elapsed since 0-01-01
    function automatic longint unsigned day_count(cal_date_t dt);
      longint unsigned y;
      longint unsigned n;
      y = 64'(dt.year);
      n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
      for (int m = 1; m < dt.month; m++) begin
        n += month_days(dt.year, m);
      end
      return n + dt.day - 1;
    endfunction

    function void note_dates(logic [47:0] data);
      cal_date_t       a;
      cal_date_t       b;
      date_verdict_t   v;
      longint unsigned na;
      longint unsigned nb;
      longint unsigned gap;
      a = data[22:0];
      b = data[45:23];
      v.first_ok  = date_ok(a);
      v.second_ok = date_ok(b);
      v.distance  = '0;
      if (v.first_ok && v.second_ok) begin
        na  = day_count(a);
        nb  = day_count(b);
        gap = (na > nb) ? na - nb : nb - na;
        if (gap > DISTANCE_CAP) begin
          gap = DISTANCE_CAP;
        end
        v.distance = gap[DIST_W-1:0];
      end
      awaited.push_back(v);
    endfunction

    function void check_result(logic [23:0] data);
      date_verdict_t v;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result %h", $time, data);
        errors++;
        return;
      end
      v = awaited.pop_front();
      if (data[0] !== v.first_ok) begin
        $display("%0t: first_valid expected %0b actual %0b", $time, v.first_ok, data[0]);
        errors++;
      end
      if (data[1] !== v.second_ok) begin
        $display("%0t: second_valid expected %0b actual %0b", $time, v.second_ok, data[1]);
        errors++;
      end
      if (data[23:2] !== v.distance) begin
        $display("%0t: day_distance expected %0d actual %0d", $time, v.distance,
                 data[23:2]);
        errors++;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;

  date_scoreboard sb = new();
  bit             no_idle = 1'b0;

  gregorian_date_difference #(.YEAR_MAX(YEAR_LIMIT)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        sb.note_dates(s_tdata);
      end
      if (m_tvalid && m_tready) begin
        sb.check_result(m_tdata);
      end
    end
  end

  function automatic cal_date_t mk(int y, int m, int d);
    cal_date_t r;
    r.year  = YEAR_W'(y);
    r.month = MONTH_W'(m);
    r.day   = DAY_W'(d);
    return r;
  endfunction

  function automatic cal_date_t random_date();
    cal_date_t r;
    int        pick;
    int        y;
    int        m;
    pick = $urandom_range(0, 99);
    y = (pick < 8) ? ((pick < 4) ? 0 : YEAR_LIMIT) : $urandom_range(0, YEAR_LIMIT);
    m = $urandom_range(1, 12);
    if (pick < 84) begin
      r = mk(y, m, $urandom_range(1, sb.month_days(y, m)));
    end else if (pick < 88) begin
      r = mk(y, 2, 29);
    end else if (pick < 92) begin
      r = mk(y, m, sb.month_days(y, m) + 1);
    end else begin
      r = {5'($urandom), 4'($urandom), 14'($urandom)};
    end
    return r;
  endfunction

  task automatic offer_dates(cal_date_t a, cal_date_t b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, b, a};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  initial begin
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  initial begin
    cal_date_t a;
    cal_date_t b;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    offer_dates(mk(0, 1, 1), mk(9999, 12, 31));
    offer_dates(mk(9999, 12, 31), mk(0, 1, 1));
    offer_dates(mk(2024, 5, 17), mk(2024, 5, 17));
    offer_dates(mk(10000, 1, 1), mk(2000, 1, 1));
    offer_dates(mk(2000, 1, 1), mk(16383, 15, 31));
    offer_dates(mk(2000, 0, 10), mk(2000, 1, 10));
    offer_dates(mk(2000, 13, 10), mk(2000, 1, 10));
    offer_dates(mk(2000, 15, 10), mk(2000, 1, 10));
    offer_dates(mk(2000, 3, 0), mk(2000, 3, 1));
    offer_dates(mk(2000, 4, 31), mk(2000, 4, 30));
    offer_dates(mk(2000, 2, 29), mk(2000, 3, 1));
    offer_dates(mk(1900, 2, 29), mk(1900, 3, 1));
    offer_dates(mk(1900, 2, 28), mk(1900, 3, 1));
    offer_dates(mk(2004, 2, 29), mk(2003, 2, 28));
    offer_dates(mk(0, 2, 29), mk(0, 3, 1));
    offer_dates(mk(2001, 2, 29), mk(2001, 2, 28));
    offer_dates(mk(2000, 2, 30), mk(2000, 2, 1));
    offer_dates(mk(1999, 12, 31), mk(2000, 1, 1));
    offer_dates(mk(0, 0, 0), mk(0, 0, 0));
    offer_dates(mk(9999, 2, 28), mk(9999, 12, 31));
    offer_dates(mk(400, 2, 29), mk(100, 2, 29));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) begin
        no_idle = ($urandom_range(0, 3) == 0);
      end
      a = random_date();
      b = ($urandom_range(0, 19) == 0) ? a : random_date();
      offer_dates(a, b);
    end
    no_idle = 1'b0;
    s_tvalid <= 1'b0;

    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
